/* rtl/core/ska_pkg.sv */
// Shared types and constants of the skyline atlas allocator.
package ska_pkg;

	localparam int PAGES_DEF   = 4;
	localparam int COLUMNS_DEF = 256;
	localparam int ROWS_DEF    = 256;

	// column and height arithmetic width; covers every legal geometry plus the border
	localparam int XW = 12;

	typedef enum logic [1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_UPLOAD = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_code_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_PAGE_INIT,
		OP_WIN_INIT,
		OP_EVAL,
		OP_NEXT_PAGE,
		OP_WR_INIT,
		OP_WR,
		OP_CLR_INIT,
		OP_CLR
	} dp_op_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_ZERO,
		RES_OK,
		RES_UPLOAD,
		RES_CLEAR
	} res_op_t;

	typedef struct packed {
		dp_op_t  op;
		res_op_t res;
	} ctrl_t;

	typedef struct packed {
		logic width_bad;
		logic page_bad;
		logic eval_stop;
		logic page_end;
		logic fits;
		logic last_page;
		logic wr_last;
		logic clr_last;
	} status_t;

endpackage

/* rtl/core/skyline_atlas_allocator.sv */
// Top level of the skyline atlas allocator.
// Packs padded rectangles into PAGES skyline pages. After reset the block
// sweeps its height memory, one entry a cycle, over all PAGES*COLUMNS entries
// before taking the first request; a clear request repeats that sweep and then
// answers. An upload or unknown request answers straight from idle. An allocate
// reads one column at a time through the single memory port, alternating a read
// state and an evaluate state, and each window it starts adds a set-up state.
// A successful placement then writes the raised height into each of the
// width+2 padded columns. One request is in flight at a time.
module skyline_atlas_allocator #(
	parameter int PAGES   = ska_pkg::PAGES_DEF,
	parameter int COLUMNS = ska_pkg::COLUMNS_DEF,
	parameter int ROWS    = ska_pkg::ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  logic [8:0] item_width,
	input  logic [8:0] item_height,
	input  logic [3:0] page,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       success,
	output logic [3:0] page_out,
	output logic [7:0] x_pos,
	output logic [7:0] y_pos
);
	import ska_pkg::*;

	ctrl_t   ctrl;
	status_t st;

	ska_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.ctrl      (ctrl)
	);

	ska_datapath #(
		.PAGES   (PAGES),
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.item_width  (item_width),
		.item_height (item_height),
		.page        (page),
		.st          (st),
		.success     (success),
		.page_out    (page_out),
		.x_pos       (x_pos),
		.y_pos       (y_pos)
	);

endmodule

/* rtl/core/ska_datapath.sv */
// Skyline memory, dirty flags, scan counters and result register.
module ska_datapath #(
	parameter int PAGES   = ska_pkg::PAGES_DEF,
	parameter int COLUMNS = ska_pkg::COLUMNS_DEF,
	parameter int ROWS    = ska_pkg::ROWS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ska_pkg::ctrl_t  ctrl,
	input  logic [8:0]      item_width,
	input  logic [8:0]      item_height,
	input  logic [3:0]      page,
	output ska_pkg::status_t st,
	output logic            success,
	output logic [3:0]      page_out,
	output logic [7:0]      x_pos,
	output logic [7:0]      y_pos
);
	import ska_pkg::*;

	localparam int DEPTH = PAGES * COLUMNS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int HW    = $clog2(ROWS + 1);
	localparam int PIW   = (PAGES > 1) ? $clog2(PAGES) : 1;

	logic [HW-1:0]    mem [DEPTH];
	logic [HW-1:0]    rdata_q;
	logic [PAGES-1:0] dirty_q;
	logic [4:0]       pg_q;
	logic [XW-1:0]    pw_q, ph_q, i_q, j_q, argmax_q, pos_q;
	logic [HW-1:0]    top_q, lowest_q;
	logic [AW-1:0]    clr_q;

	logic [XW-1:0] col, raised, j_inc, next_i, argmax_n;
	logic [HW-1:0] top_n;
	logic [15:0]   addr_full;
	logic [AW-1:0] addr;
	logic          h_fail, win_last, up_hit;

	assign j_inc    = j_q + XW'(1);
	assign raised   = XW'(lowest_q) + ph_q;
	assign h_fail   = rdata_q >= lowest_q;
	assign win_last = j_inc == pw_q;
	assign top_n    = (rdata_q > top_q) ? rdata_q : top_q;
	assign argmax_n = (rdata_q >= top_q) ? (i_q + j_q) : argmax_q;
	// windows up to the blocking column all contain it, so skip past it
	assign next_i   = h_fail ? (i_q + j_q + XW'(1)) : (argmax_n + XW'(1));

	always_comb begin
		if (ctrl.op == OP_WR || ctrl.op == OP_WR_INIT)
			col = pos_q + j_q;
		else
			col = i_q + j_q;
		addr_full = 16'(pg_q) * 16'(COLUMNS) + 16'(col);
		addr = (ctrl.op == OP_CLR) ? clr_q : addr_full[AW-1:0];
	end

	assign up_hit = (5'(page) < 5'(PAGES)) && dirty_q[page[PIW-1:0]];

	assign st.width_bad = 11'(pw_q) > 11'(COLUMNS);
	assign st.page_bad  = pg_q >= 5'(PAGES);
	assign st.eval_stop = h_fail || win_last;
	assign st.page_end  = (next_i + pw_q) > XW'(COLUMNS);
	assign st.fits      = raised <= XW'(ROWS);
	assign st.last_page = (pg_q + 5'd1) >= 5'(PAGES);
	assign st.wr_last   = j_inc == pw_q;
	assign st.clr_last  = clr_q == AW'(DEPTH - 1);

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_CLR)
			mem[addr] <= '0;
		else if (ctrl.op == OP_WR)
			mem[addr] <= raised[HW-1:0];
		rdata_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= '0;
			clr_q   <= '0;
		end else begin
			if (ctrl.op == OP_CLR_INIT) begin
				dirty_q <= '0;
				clr_q   <= '0;
			end else if (ctrl.op == OP_CLR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (ctrl.res == RES_UPLOAD && up_hit)
				dirty_q[page[PIW-1:0]] <= 1'b0;
			else if (ctrl.res == RES_OK)
				dirty_q[pg_q[PIW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				pg_q <= {1'b0, page};
				pw_q <= XW'(item_width) + XW'(2);
				ph_q <= XW'(item_height) + XW'(2);
			end
			OP_PAGE_INIT: begin
				i_q      <= '0;
				pos_q    <= '0;
				lowest_q <= HW'(ROWS);
			end
			OP_WIN_INIT: begin
				j_q   <= '0;
				top_q <= '0;
			end
			OP_EVAL: begin
				if (h_fail) begin
					i_q <= next_i;
				end else if (win_last) begin
					lowest_q <= top_n;
					pos_q    <= i_q;
					i_q      <= next_i;
				end else begin
					j_q      <= j_inc;
					top_q    <= top_n;
					argmax_q <= argmax_n;
				end
			end
			OP_NEXT_PAGE: pg_q <= pg_q + 5'd1;
			OP_WR_INIT:   j_q <= '0;
			OP_WR:        j_q <= j_inc;
			default: ;
		endcase

		case (ctrl.res)
			RES_OK: begin
				success  <= 1'b1;
				page_out <= pg_q[3:0];
				x_pos    <= 8'(pos_q + XW'(1));
				y_pos    <= 8'(XW'(lowest_q) + XW'(1));
			end
			RES_UPLOAD, RES_CLEAR, RES_ZERO: begin
				success  <= (ctrl.res == RES_CLEAR) || (ctrl.res == RES_UPLOAD && up_hit);
				page_out <= '0;
				x_pos    <= '0;
				y_pos    <= '0;
			end
			default: ;
		endcase
	end

endmodule

/* rtl/core/ska_ctrl.sv */
// Sequencer of the allocator: clearing sweep, skyline scan, raise and handshakes.
module ska_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        command,
	output logic              out_valid,
	input  logic              out_ready,
	input  ska_pkg::status_t  st,
	output ska_pkg::ctrl_t    ctrl
);
	import ska_pkg::*;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_CLR, S_PAGE, S_WIN, S_RD, S_EV, S_FIT, S_WR
	} state_t;

	state_t state_q, state_n;
	logic   out_valid_q;

	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);

	always_comb begin
		state_n   = state_q;
		ctrl.op   = OP_NONE;
		ctrl.res  = RES_NONE;
		unique case (state_q)
			S_INIT: begin
				ctrl.op = OP_CLR;
				if (st.clr_last)
					state_n = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid && in_ready) begin
					unique case (command)
						CMD_ALLOC: begin
							ctrl.op = OP_LOAD;
							state_n = S_PAGE;
						end
						CMD_UPLOAD: ctrl.res = RES_UPLOAD;
						CMD_CLEAR: begin
							ctrl.op = OP_CLR_INIT;
							state_n = S_CLR;
						end
						default: ctrl.res = RES_ZERO;
					endcase
				end
			end
			S_CLR: begin
				ctrl.op = OP_CLR;
				if (st.clr_last) begin
					ctrl.res = RES_CLEAR;
					state_n  = S_IDLE;
				end
			end
			S_PAGE: begin
				if (st.width_bad || st.page_bad) begin
					ctrl.res = RES_ZERO;
					state_n  = S_IDLE;
				end else begin
					ctrl.op = OP_PAGE_INIT;
					state_n = S_WIN;
				end
			end
			S_WIN: begin
				ctrl.op = OP_WIN_INIT;
				state_n = S_RD;
			end
			S_RD: state_n = S_EV;
			S_EV: begin
				ctrl.op = OP_EVAL;
				if (st.eval_stop)
					state_n = st.page_end ? S_FIT : S_WIN;
				else
					state_n = S_RD;
			end
			S_FIT: begin
				if (st.fits) begin
					ctrl.op = OP_WR_INIT;
					state_n = S_WR;
				end else if (st.last_page) begin
					ctrl.res = RES_ZERO;
					state_n  = S_IDLE;
				end else begin
					ctrl.op = OP_NEXT_PAGE;
					state_n = S_PAGE;
				end
			end
			S_WR: begin
				ctrl.op = OP_WR;
				if (st.wr_last) begin
					ctrl.res = RES_OK;
					state_n  = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctrl.res != RES_NONE)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_ready_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!out_valid_q || out_ready))
		else $error("request taken while result slot busy");

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.res != RES_NONE) |=> (state_q == S_IDLE) && out_valid_q)
		else $error("result issued without returning to idle");

	a_init_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT || state_q == S_CLR) |-> !in_ready)
		else $error("request taken during clearing sweep");

endmodule

/* bench/tb_skyline_atlas_allocator.sv */
// Testbench for the skyline atlas allocator: directed and random requests checked against a predictor.
module tb_skyline_atlas_allocator;
	timeunit 1ns;
	timeprecision 1ps;
	import ska_pkg::*;

	localparam int NPAGE = PAGES_DEF;
	localparam int NCOL = COLUMNS_DEF;
	localparam int NROW = ROWS_DEF;
	localparam int PAD = 2;
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam int STALL_LIMIT = 2000000;
	localparam int RANDOM_REQS = 1000;

	typedef struct {
		logic       success;
		logic [3:0] page_out;
		logic [7:0] x_pos;
		logic [7:0] y_pos;
	} answer_t;

	class atlas_scoreboard;
		int sky[NPAGE][NCOL];
		bit dirty[NPAGE];
		answer_t awaited[$];
		int errors;

		function new();
			wipe();
			errors = 0;
		endfunction

		function void wipe();
			foreach (sky[p, c]) sky[p][c] = 0;
			foreach (dirty[p]) dirty[p] = 0;
		endfunction

		// leftmost window whose tallest column is strictly lowest, then the fit test
		function bit try_page(int pg, int pw, int ph, output int px, output int py);
			int lowest, pos, top;
			bit ok;
			lowest = NROW;
			pos = 0;
			px = 0;
			py = 0;
			if (pw > NCOL)
				return 0;
			for (int i = 0; i + pw <= NCOL; i++) begin
				top = 0;
				ok = 1;
				for (int j = 0; j < pw; j++) begin
					if (sky[pg][i+j] >= lowest) begin
						ok = 0;
						break;
					end
					if (sky[pg][i+j] > top)
						top = sky[pg][i+j];
				end
				if (ok) begin
					pos = i;
					lowest = top;
				end
			end
			if (lowest + ph > NROW)
				return 0;
			for (int j = 0; j < pw; j++)
				sky[pg][pos+j] = lowest + ph;
			px = pos;
			py = lowest;
			return 1;
		endfunction

		function void note_request(logic [1:0] cmd, int w, int h, int pg);
			answer_t a;
			int x, y;
			a = '{1'b0, 4'd0, 8'd0, 8'd0};
			case (cmd)
				CMD_ALLOC: begin
					for (int p = pg; p < NPAGE; p++) begin
						if (try_page(p, w + PAD, h + PAD, x, y)) begin
							dirty[p] = 1;
							a.success = 1;
							a.page_out = p[3:0];
							a.x_pos = 8'(x + 1);
							a.y_pos = 8'(y + 1);
							break;
						end
					end
				end
				CMD_UPLOAD: begin
					if (pg < NPAGE && dirty[pg]) begin
						dirty[pg] = 0;
						a.success = 1;
					end
				end
				CMD_CLEAR: begin
					wipe();
					a.success = 1;
				end
				default: ;
			endcase
			awaited.push_back(a);
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_result(logic s, logic [3:0] p, logic [7:0] x, logic [7:0] y);
			answer_t a;
			if (awaited.size() == 0) begin
				report("result with no request outstanding");
				return;
			end
			a = awaited.pop_front();
			if (s !== a.success)
				report($sformatf("success %b, predicted %b", s, a.success));
			if (p !== a.page_out)
				report($sformatf("page_out %0d, predicted %0d", p, a.page_out));
			if (x !== a.x_pos)
				report($sformatf("x_pos %0d, predicted %0d", x, a.x_pos));
			if (y !== a.y_pos)
				report($sformatf("y_pos %0d, predicted %0d", y, a.y_pos));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] command;
	logic [8:0] item_width;
	logic [8:0] item_height;
	logic [3:0] page;
	logic out_valid;
	logic out_ready;
	logic success;
	logic [3:0] page_out;
	logic [7:0] x_pos;
	logic [7:0] y_pos;

	atlas_scoreboard sb;
	bit calm;
	bit hold_req;
	int quiet_cycles;

	skyline_atlas_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .item_width(item_width),
		.item_height(item_height), .page(page),
		.out_valid(out_valid), .out_ready(out_ready),
		.success(success), .page_out(page_out),
		.x_pos(x_pos), .y_pos(y_pos)
	);

	always #5 clk = ~clk;

	task send_request(logic [1:0] cmd, int w, int h, int pg);
		if (!calm && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		item_width <= 9'(w);
		item_height <= 9'(h);
		page <= 4'(pg);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(cmd, w, h, pg);
	endtask

	task send_random();
		int r, w, h, pg;
		logic [1:0] cmd;
		r = $urandom_range(99);
		cmd = r < 70 ? CMD_ALLOC : r < 86 ? CMD_UPLOAD : r < 96 ? CMD_CLEAR : CMD_UNKNOWN;
		r = $urandom_range(99);
		// wide windows make the scan slow, so keep them rare
		w = r < 88 ? $urandom_range(0, 20) : r < 98 ? $urandom_range(0, 80) : $urandom_range(0, 256);
		h = $urandom_range(99) < 90 ? $urandom_range(0, 40) : $urandom_range(0, 256);
		pg = $urandom_range(99) < 80 ? $urandom_range(0, NPAGE - 1) : $urandom_range(0, 15);
		send_request(cmd, w, h, pg);
	endtask

	// receiver: check on handshake, then pick next ready
	initial begin
		int hold;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result(success, page_out, x_pos, y_pos);
			if (hold_req) begin
				hold_req = 0;
				out_ready <= 1'b0;
				for (hold = 0; hold < 3000; hold++) @(posedge clk);
			end
			out_ready <= calm || $urandom_range(99) >= 18;
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int guard;
		sb = new();
		clk = 0;
		arst_n = 0;
		in_valid = 0;
		out_ready = 0;
		command = CMD_ALLOC;
		item_width = 0;
		item_height = 0;
		page = 0;
		calm = 0;
		hold_req = 0;
		quiet_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(CMD_ALLOC, 0, 0, 0);
		send_request(CMD_ALLOC, 254, 0, 0);     // full page width
		send_request(CMD_ALLOC, 255, 5, 0);     // padded width too wide
		send_request(CMD_ALLOC, 256, 5, 1);
		send_request(CMD_ALLOC, 10, 256, 1);    // padded height never fits
		send_request(CMD_ALLOC, 20, 254, 1);    // exact height fill
		send_request(CMD_ALLOC, 20, 254, 1);    // fits beside the first on the same page
		send_request(CMD_ALLOC, 3, 3, 3);
		send_request(CMD_ALLOC, 3, 3, 4);       // start page out of range
		send_request(CMD_ALLOC, 3, 3, 15);
		send_request(CMD_UPLOAD, 0, 0, 0);
		send_request(CMD_UPLOAD, 0, 0, 0);      // already taken
		send_request(CMD_UPLOAD, 0, 0, 2);
		send_request(CMD_UPLOAD, 0, 0, 9);
		send_request(CMD_UNKNOWN, 511, 511, 15);
		send_request(CMD_CLEAR, 0, 0, 0);
		send_request(CMD_UPLOAD, 0, 0, 1);
		for (int i = 0; i < 6; i++)
			send_request(CMD_ALLOC, 30 + 7 * i, 100 - 9 * i, 0);
		send_request(CMD_ALLOC, 200, 150, 0);
		send_request(CMD_ALLOC, 250, 250, 0);   // needs an almost empty page
		send_request(CMD_CLEAR, 0, 0, 0);

		for (int n = 0; n < RANDOM_REQS; n++) begin
			calm = n >= 200 && n < 400;
			if (n == 600)
				hold_req = 1;
			send_random();
		end
		in_valid <= 1'b0;
		calm = 0;

		guard = 0;
		while (sb.awaited.size() != 0 && guard < STALL_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
